[sv/mpcb_pkg.sv]
// ----------------------------------------------------------------------------
// mpcb_pkg
// Shared widths, codes and controller/datapath interface types of the
// multi-axis proportional controller with bias compensation.
// ----------------------------------------------------------------------------
package mpcb_pkg;

    localparam int AXES          = 4;
    localparam int AXIS_BITS     = 2;
    localparam int FRAC_BITS     = 8;
    localparam int POS_BITS      = 16;
    localparam int DIFF_BITS     = POS_BITS + 1;
    localparam int MAG_BITS      = POS_BITS;
    localparam int SPEED_BITS    = 24;
    localparam int LIM_BITS      = 12;
    localparam int ACC_BITS      = 10;
    localparam int PWM_BITS      = 16;
    localparam int DUTY_BITS     = 8;
    localparam int PROD_BITS     = MAG_BITS + LIM_BITS;
    localparam int QUO_BITS      = LIM_BITS + FRAC_BITS;
    localparam int CAP_BITS      = LIM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS  = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = AXES * POS_BITS;
    localparam int OUT_DATA_BITS = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCURACY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PWM_SCALE      = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [LIM_BITS-1:0] SPEED_LIMIT_RESET    = 12'd100;
    localparam logic [ACC_BITS-1:0] ACCURACY_LIMIT_RESET = 10'd2;
    localparam logic [PWM_BITS-1:0] PWM_SCALE_RESET      = 16'd256;

    typedef struct packed {
        logic                 load_tgt;
        logic                 load_pos;
        logic                 scan;
        logic                 scan_last;
        logic                 mul;
        logic                 div_init;
        logic                 div_step;
        logic                 ideal;
        logic                 pwm;
        logic                 drive_done;
        logic                 out_load;
        logic [AXIS_BITS-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic arrived;
        logic out_valid;
        logic out_free;
    } status_t;

endpackage

[sv/mpcb_ctrl.sv]
// ----------------------------------------------------------------------------
// mpcb_ctrl
// Sequencer: walks the axes through scan, scaling division, bias and duty
// steps, and hands finished results to the output register.
// ----------------------------------------------------------------------------
module mpcb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_op,
    output logic             in_ready,
    input  mpcb_pkg::status_t st,
    output mpcb_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHECK, S_MUL, S_DIVI, S_DIV, S_IDEAL, S_PWM, S_OUT
    } state_t;

    localparam logic [mpcb_pkg::AXIS_BITS-1:0] LAST_AXIS =
        mpcb_pkg::AXIS_BITS'(mpcb_pkg::AXES - 1);
    localparam logic [mpcb_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
        mpcb_pkg::DIV_CNT_BITS'(mpcb_pkg::QUO_BITS - 1);

    state_t                              state_reg, state_next;
    logic [mpcb_pkg::AXIS_BITS-1:0]      axis_reg, axis_next;
    logic [mpcb_pkg::DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                                last_axis;

    assign in_ready  = (state_reg == S_IDLE);
    assign last_axis = (axis_reg == LAST_AXIS);

    always_comb begin
        cmd            = '0;
        cmd.axis       = axis_reg;
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.load_tgt = in_valid && (in_op == mpcb_pkg::OP_LOAD);
                cmd.load_pos = in_valid && (in_op == mpcb_pkg::OP_SAMPLE);
                if (cmd.load_pos) begin
                    state_next = S_SCAN;
                    axis_next  = '0;
                end
            end
            S_SCAN: begin
                cmd.scan      = 1'b1;
                cmd.scan_last = last_axis;
                if (last_axis) begin
                    state_next = S_CHECK;
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            S_CHECK: begin
                axis_next  = '0;
                state_next = st.arrived ? S_OUT : S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = st.need_div ? S_DIV : S_IDEAL;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = S_IDEAL;
                end
            end
            S_IDEAL: begin
                cmd.ideal  = 1'b1;
                state_next = S_PWM;
            end
            S_PWM: begin
                cmd.pwm        = 1'b1;
                cmd.drive_done = last_axis;
                if (last_axis) begin
                    state_next = S_OUT;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OUT: begin
                cmd.out_load = st.out_free;
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> st.out_valid)
        else $error("loaded result not presented");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg <= LAST_STEP))
        else $error("division ran past its steps");
    a_sample_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_pos |=> (state_reg == S_SCAN) && (axis_reg == '0))
        else $error("sample did not start the scan");
`endif

endmodule

[sv/mpcb_datapath.sv]
// ----------------------------------------------------------------------------
// mpcb_datapath
// Registers, stored axis state, shared multipliers, restoring divider and
// output register of the controller.
// ----------------------------------------------------------------------------
module mpcb_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  mpcb_pkg::cmd_t                         cmd,
    output mpcb_pkg::status_t                      st,
    input  logic [mpcb_pkg::IN_DATA_BITS-1:0]      in_data,
    input  logic                                   cfg_we,
    input  logic [mpcb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [mpcb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mpcb_pkg::OUT_DATA_BITS-1:0]     out_data,
    output logic                                   out_arrived
);

    localparam int AX  = mpcb_pkg::AXES;
    localparam int PB  = mpcb_pkg::POS_BITS;
    localparam int DB  = mpcb_pkg::DIFF_BITS;
    localparam int MB  = mpcb_pkg::MAG_BITS;
    localparam int SB  = mpcb_pkg::SPEED_BITS;
    localparam int FB  = mpcb_pkg::FRAC_BITS;
    localparam int QB  = mpcb_pkg::QUO_BITS;
    localparam int CB  = mpcb_pkg::CAP_BITS;
    localparam int LB  = mpcb_pkg::LIM_BITS;
    localparam int WB  = mpcb_pkg::PWM_BITS;
    localparam int UB  = mpcb_pkg::DUTY_BITS;
    localparam int PRB = mpcb_pkg::PROD_BITS;
    localparam int BSB = SB + 2;
    localparam int BDB = SB + 1;
    localparam int DPB = CB + WB;

    logic [mpcb_pkg::LIM_BITS-1:0] lim_reg;
    logic [mpcb_pkg::ACC_BITS-1:0] acc_reg;
    logic [WB-1:0]                 pwm_reg;

    logic signed [PB-1:0] target_reg [AX];
    logic signed [PB-1:0] pos_reg    [AX];
    logic signed [PB-1:0] prev_reg   [AX];
    logic signed [DB-1:0] diff_reg   [AX];
    logic signed [SB-1:0] ideal_reg  [AX];
    logic signed [SB-1:0] bias_reg   [2*AX];
    logic                 dir_reg    [AX];
    logic [UB-1:0]        duty_reg   [AX];
    logic                 pending_reg;
    logic                 arrived_reg;
    logic [MB-1:0]        maxabs_reg;
    logic [PRB-1:0]       prod_reg;
    logic [MB-1:0]        rem_reg;
    logic [QB-1:0]        shift_reg;
    logic [QB-1:0]        quo_reg;
    logic [CB-1:0]        mag_reg;
    logic                 out_valid_reg;
    logic                 out_arrived_reg;
    logic [mpcb_pkg::OUT_DATA_BITS-1:0] out_data_reg;
    logic [mpcb_pkg::OUT_DATA_BITS-1:0] out_pack;

    // scan step
    logic signed [PB-1:0]  s_pos, s_prev, s_tgt;
    logic signed [DB-1:0]  s_diff, s_moved;
    logic [MB-1:0]         s_absdiff;
    logic signed [BSB-1:0] s_bias_wide;
    logic signed [SB-1:0]  s_bias_sat;
    logic                  s_bias_sel;
    logic signed [SB-1:0]  s_ideal_old;

    // division step
    logic [MB:0]           d_trial;
    logic                  d_ge;

    // ideal and bias step
    logic signed [DB-1:0]  i_diff;
    logic [MB-1:0]         i_absdiff;
    logic signed [SB-1:0]  i_ideal;
    logic                  i_fwd;
    logic signed [BDB-1:0] i_biased, i_cap;
    logic signed [BDB-1:0] i_clamped;

    // pwm step
    logic [DPB-1:0]        p_prod;
    logic [DPB-FB-FB-1:0]  p_wide;
    logic [UB-1:0]         p_duty;

    localparam logic signed [BSB-1:0] SAT_HI = BSB'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [BSB-1:0] SAT_LO = -SAT_HI - BSB'(1);

    assign s_pos       = pos_reg[cmd.axis];
    assign s_prev      = prev_reg[cmd.axis];
    assign s_tgt       = target_reg[cmd.axis];
    assign s_diff      = DB'(s_tgt) - DB'(s_pos);
    assign s_absdiff   = s_diff[DB-1] ? MB'(-s_diff) : MB'(s_diff);
    assign s_moved     = DB'(s_pos) - DB'(s_prev);
    assign s_ideal_old = ideal_reg[cmd.axis];
    assign s_bias_sel  = !(s_ideal_old > 0);
    assign s_bias_wide = BSB'(s_ideal_old) - (BSB'(s_moved) <<< FB);
    assign s_bias_sat  = (s_bias_wide > SAT_HI) ? SB'(SAT_HI) :
                         (s_bias_wide < SAT_LO) ? SB'(SAT_LO) : SB'(s_bias_wide);

    assign d_trial = {rem_reg, shift_reg[QB-1]};
    assign d_ge    = (d_trial >= {1'b0, maxabs_reg});

    assign i_diff    = diff_reg[cmd.axis];
    assign i_absdiff = i_diff[DB-1] ? MB'(-i_diff) : MB'(i_diff);
    always_comb begin
        if (st.need_div) begin
            i_ideal = i_diff[DB-1] ? -SB'(quo_reg) : SB'(quo_reg);
        end else begin
            i_ideal = SB'(i_diff) <<< FB;
        end
    end
    assign i_fwd     = (i_ideal > 0);
    assign i_biased  = BDB'(i_ideal) + BDB'(bias_reg[{cmd.axis, !i_fwd}]);
    assign i_cap     = BDB'({lim_reg, {FB{1'b0}}});
    assign i_clamped = (i_biased > i_cap) ? i_cap :
                       (i_biased < -i_cap) ? -i_cap : i_biased;

    assign p_prod = DPB'(mag_reg) * DPB'(pwm_reg);
    assign p_wide = p_prod[DPB-1:FB+FB];
    assign p_duty = (p_wide > (DPB-FB-FB)'({UB{1'b1}})) ? {UB{1'b1}} : UB'(p_wide);

    assign st.need_div  = (maxabs_reg > MB'(lim_reg));
    assign st.arrived   = arrived_reg;
    assign st.out_valid = out_valid_reg;
    assign st.out_free  = !out_valid_reg || out_ready;

    always_comb begin
        out_pack = '0;
        for (int i = 0; i < AX; i++) begin
            out_pack[i]               = dir_reg[i];
            out_pack[AX + i*UB +: UB] = duty_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= mpcb_pkg::SPEED_LIMIT_RESET;
            acc_reg <= mpcb_pkg::ACCURACY_LIMIT_RESET;
            pwm_reg <= mpcb_pkg::PWM_SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mpcb_pkg::REG_SPEED_LIMIT:    lim_reg <= cfg_data[LB-1:0];
                mpcb_pkg::REG_ACCURACY_LIMIT: acc_reg <= cfg_data[mpcb_pkg::ACC_BITS-1:0];
                mpcb_pkg::REG_PWM_SCALE:      pwm_reg <= cfg_data[WB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AX; i++) begin
                target_reg[i] <= '0;
                prev_reg[i]   <= '0;
                ideal_reg[i]  <= '0;
                dir_reg[i]    <= 1'b0;
                duty_reg[i]   <= '0;
            end
            for (int i = 0; i < 2*AX; i++) begin
                bias_reg[i] <= '0;
            end
            pending_reg <= 1'b0;
        end else begin
            if (cmd.load_tgt) begin
                for (int i = 0; i < AX; i++) begin
                    target_reg[i] <= in_data[i*PB +: PB];
                end
            end
            if (cmd.scan) begin
                if (pending_reg) begin
                    bias_reg[{cmd.axis, s_bias_sel}] <= s_bias_sat;
                end
                prev_reg[cmd.axis] <= s_pos;
                if (cmd.scan_last) begin
                    pending_reg <= 1'b0;
                end
            end
            if (cmd.ideal) begin
                ideal_reg[cmd.axis] <= i_ideal;
                dir_reg[cmd.axis]   <= i_fwd;
            end
            if (cmd.pwm) begin
                duty_reg[cmd.axis] <= p_duty;
            end
            if (cmd.drive_done) begin
                pending_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pos) begin
            for (int i = 0; i < AX; i++) begin
                pos_reg[i] <= in_data[i*PB +: PB];
            end
            maxabs_reg  <= '0;
            arrived_reg <= 1'b1;
        end
        if (cmd.scan) begin
            diff_reg[cmd.axis] <= s_diff;
            if (s_absdiff > maxabs_reg) begin
                maxabs_reg <= s_absdiff;
            end
            if (s_absdiff > MB'(acc_reg)) begin
                arrived_reg <= 1'b0;
            end
        end
        if (cmd.mul) begin
            prod_reg <= PRB'(i_absdiff) * PRB'(lim_reg);
        end
        if (cmd.div_init) begin
            rem_reg   <= prod_reg[PRB-1:PRB-MB];
            shift_reg <= {prod_reg[PRB-MB-1:0], {FB{1'b0}}};
            quo_reg   <= '0;
        end
        if (cmd.div_step) begin
            rem_reg   <= d_ge ? MB'(d_trial - {1'b0, maxabs_reg}) : MB'(d_trial);
            shift_reg <= {shift_reg[QB-2:0], 1'b0};
            quo_reg   <= {quo_reg[QB-2:0], d_ge};
        end
        if (cmd.ideal) begin
            mag_reg <= i_clamped[BDB-1] ? CB'(-i_clamped) : CB'(i_clamped);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_arrived_reg <= arrived_reg;
            out_data_reg    <= out_pack;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign out_arrived = out_arrived_reg;

`ifndef NO_ASSERTIONS
    a_pending_after_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drive_done |=> pending_reg)
        else $error("drive did not leave a pending bias update");
    a_no_drive_arrived: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul |-> !arrived_reg)
        else $error("drive computed although all axes arrived");
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.div_init) && st.need_div |-> (rem_reg < maxabs_reg))
        else $error("scaled quotient exceeds its width");
`endif

endmodule

[sv/multi_axis_p_control_bias.sv]
// ----------------------------------------------------------------------------
// multi_axis_p_control_bias
// Four-axis proportional position controller with learned direction bias.
// ----------------------------------------------------------------------------
// One item at a time. A target load (tuser 0) gives no result. A position
// sample (tuser 1) is accepted, scanned axis by axis and checked; when all
// axes have arrived it goes straight to the output, otherwise each axis in
// turn is multiplied, scaled, biased and turned into a duty value. The
// speed is scaled by the shared restoring divider (one quotient bit a cycle)
// when the largest error exceeds the speed limit. The result enters the
// output register once a previous result there is taken. The output register
// holds a result while the next item is accepted.
module multi_axis_p_control_bias (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_first_x, pos_first_y, pos_second_x, pos_second_y
    input  logic [mpcb_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // opcode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // dir_first_x, dir_first_y, dir_second_x, dir_second_y,
    // duty_first_x, duty_first_y, duty_second_x, duty_second_y, zero pad
    output logic [mpcb_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // arrived
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mpcb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [mpcb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    mpcb_pkg::cmd_t    cmd;
    mpcb_pkg::status_t st;

    assign cfg_ready = 1'b1;

    mpcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mpcb_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .in_data     (s_tdata),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_arrived (m_tuser)
    );

endmodule

[tb/tb_multi_axis_p_control_bias.sv]
// ----------------------------------------------------------------------------
// tb_multi_axis_p_control_bias
// Self-checking bench for the four-axis proportional controller: drives
// target loads and position samples over the input stream, predicts every
// drive result with its own copy of targets, biases and registers, and
// compares each result field by field under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_multi_axis_p_control_bias;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mpcb_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 150;

    typedef logic signed [mpcb_pkg::POS_BITS-1:0] pos_vec_t [mpcb_pkg::AXES];
    typedef struct packed {
        logic                                          arrived;
        logic [mpcb_pkg::AXES-1:0]                     dir;
        logic [mpcb_pkg::AXES*mpcb_pkg::DUTY_BITS-1:0] duty;
    } drive_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mpcb_pkg::IN_DATA_BITS-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mpcb_pkg::OUT_DATA_BITS-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mpcb_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [mpcb_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    multi_axis_p_control_bias dut (.*);

    always #5 aclk = ~aclk;

    // controller copy
    longint tgt [mpcb_pkg::AXES];
    longint prev_pos [mpcb_pkg::AXES];
    longint ideal_spd [mpcb_pkg::AXES];
    longint dir_bias [mpcb_pkg::AXES*2];
    bit     pending;
    bit     last_dir [mpcb_pkg::AXES];
    longint last_duty [mpcb_pkg::AXES];
    longint lim_reg, acc_reg, scale_reg;

    drive_t expected_drives [$];
    int     errors = 0;
    int     hold_left = 0;
    int     stall_left = 0;
    bit     no_idle = 1'b0;

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void predict_drive(logic op, pos_vec_t p);
        longint diff [mpcb_pkg::AXES];
        longint maxabs, ideal, biased, cap, duty;
        bit     arr;
        bit     fwd;
        drive_t d;
        maxabs = 0;
        arr = 1'b1;
        if (op == mpcb_pkg::OP_LOAD) begin
            for (int i = 0; i < mpcb_pkg::AXES; i++) tgt[i] = longint'(p[i]);
            return;
        end
        if (pending) begin
            for (int i = 0; i < mpcb_pkg::AXES; i++)
                dir_bias[i*2 + (ideal_spd[i] > 0 ? 0 : 1)] =
                    sat24(ideal_spd[i] - (longint'(p[i]) - prev_pos[i]) * 256);
            pending = 1'b0;
        end
        for (int i = 0; i < mpcb_pkg::AXES; i++) begin
            prev_pos[i] = longint'(p[i]);
            diff[i] = tgt[i] - longint'(p[i]);
            if (mag(diff[i]) > acc_reg) arr = 1'b0;
            if (mag(diff[i]) > maxabs) maxabs = mag(diff[i]);
        end
        d.arrived = arr;
        if (!arr) begin
            for (int i = 0; i < mpcb_pkg::AXES; i++) begin
                if (maxabs > lim_reg && maxabs > 0)
                    ideal = (diff[i] * lim_reg * 256) / maxabs;
                else
                    ideal = diff[i] * 256;
                ideal_spd[i] = ideal;
                fwd = ideal > 0;
                biased = ideal + dir_bias[i*2 + (fwd ? 0 : 1)];
                cap = lim_reg * 256;
                if (biased > cap) biased = cap;
                if (biased < -cap) biased = -cap;
                duty = (mag(biased) * scale_reg) >>> 16;
                if (duty > 255) duty = 255;
                last_dir[i] = fwd;
                last_duty[i] = duty;
            end
            pending = 1'b1;
        end
        for (int i = 0; i < mpcb_pkg::AXES; i++) begin
            d.dir[i] = last_dir[i];
            d.duty[i*mpcb_pkg::DUTY_BITS +: mpcb_pkg::DUTY_BITS] =
                last_duty[i][mpcb_pkg::DUTY_BITS-1:0];
        end
        expected_drives.push_back(d);
    endfunction

    // result side: stalls and the long hold-off
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            stall_left = no_idle ? 0 : $urandom_range(0, 12);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        drive_t exp_d;
        drive_t got;
        bit     bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.arrived = m_tuser;
            got.dir = m_tdata[mpcb_pkg::AXES-1:0];
            got.duty = m_tdata[mpcb_pkg::AXES +: mpcb_pkg::AXES*mpcb_pkg::DUTY_BITS];
            if (expected_drives.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h/%b", m_tdata, m_tuser);
            end else begin
                exp_d = expected_drives.pop_front();
                bad = exp_d.arrived !== got.arrived;
                for (int i = 0; i < mpcb_pkg::AXES; i++)
                    if (exp_d.dir[i] !== got.dir[i] ||
                        exp_d.duty[i*mpcb_pkg::DUTY_BITS +: mpcb_pkg::DUTY_BITS] !==
                        got.duty[i*mpcb_pkg::DUTY_BITS +: mpcb_pkg::DUTY_BITS])
                        bad = 1'b1;
                if (bad) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: arrived %b/%b dir %b/%b duty %h/%h (exp/got)",
                                 exp_d.arrived, got.arrived, exp_d.dir, got.dir,
                                 exp_d.duty, got.duty);
                end
            end
        end
    end

    task automatic send_item(logic op, pos_vec_t p);
        int gap;
        logic [mpcb_pkg::IN_DATA_BITS-1:0] data;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        for (int i = 0; i < mpcb_pkg::AXES; i++)
            data[i*mpcb_pkg::POS_BITS +: mpcb_pkg::POS_BITS] = p[i];
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predict_drive(op, p);
    endtask

    task automatic send_all(logic op, int a, int b, int c, int d);
        pos_vec_t p;
        p[0] = mpcb_pkg::POS_BITS'(a);
        p[1] = mpcb_pkg::POS_BITS'(b);
        p[2] = mpcb_pkg::POS_BITS'(c);
        p[3] = mpcb_pkg::POS_BITS'(d);
        send_item(op, p);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [mpcb_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [mpcb_pkg::CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            mpcb_pkg::REG_SPEED_LIMIT:    lim_reg = val[mpcb_pkg::LIM_BITS-1:0];
            mpcb_pkg::REG_ACCURACY_LIMIT: acc_reg = val[mpcb_pkg::ACC_BITS-1:0];
            mpcb_pkg::REG_PWM_SCALE:      scale_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(int lim, int acc, int scale);
        wait_idle();
        write_reg(mpcb_pkg::REG_SPEED_LIMIT, mpcb_pkg::CFG_DATA_BITS'(lim));
        write_reg(mpcb_pkg::REG_ACCURACY_LIMIT, mpcb_pkg::CFG_DATA_BITS'(acc));
        write_reg(mpcb_pkg::REG_PWM_SCALE, mpcb_pkg::CFG_DATA_BITS'(scale));
    endtask

    task automatic test_directed();
        send_all(mpcb_pkg::OP_SAMPLE, 0, 0, 0, 0);
        send_all(mpcb_pkg::OP_SAMPLE, 1, -2, 2, 0);
        send_all(mpcb_pkg::OP_LOAD, 32767, -32768, 0, 100);
        send_all(mpcb_pkg::OP_SAMPLE, -32768, 32767, 0, 100);
        send_all(mpcb_pkg::OP_SAMPLE, -32000, 32000, 5, 100);
        send_all(mpcb_pkg::OP_SAMPLE, 32767, -32768, 1, 99);
        send_all(mpcb_pkg::OP_LOAD, 50, -50, 10, -10);
        send_all(mpcb_pkg::OP_SAMPLE, 0, 0, 0, 0);
        send_all(mpcb_pkg::OP_SAMPLE, 20, -20, 4, -4);
        send_all(mpcb_pkg::OP_SAMPLE, 49, -51, 10, -8);
        send_all(mpcb_pkg::OP_SAMPLE, 50, -50, 10, -10);
        send_all(mpcb_pkg::OP_SAMPLE, 0, 0, 0, 0);
        set_regs(0, 0, 65535);
        send_all(mpcb_pkg::OP_SAMPLE, 1, 0, 0, 0);
        send_all(mpcb_pkg::OP_SAMPLE, -32768, 32767, -32768, 32767);
        set_regs(4095, 1023, 0);
        write_reg(REG_SPARE, 16'hFFFF);
        send_all(mpcb_pkg::OP_SAMPLE, -1000, 900, 0, 0);
        send_all(mpcb_pkg::OP_SAMPLE, 50, -50, 10, -10);
        set_regs(4095, 0, 65535);
        send_all(mpcb_pkg::OP_SAMPLE, -32768, -32768, 32767, 32767);
        send_all(mpcb_pkg::OP_SAMPLE, 100, 100, 100, 100);
    endtask

    task automatic run_episodes(int count);
        pos_vec_t t, p;
        int steps, span;
        for (int n = 0; n < count; ) begin
            span = ($urandom_range(0, 3) == 0) ? 32767 : int'($urandom_range(10, 3000));
            for (int i = 0; i < mpcb_pkg::AXES; i++) begin
                t[i] = mpcb_pkg::POS_BITS'(int'($urandom_range(0, 2*span)) - span);
                p[i] = mpcb_pkg::POS_BITS'(int'($urandom_range(0, 2*span)) - span);
            end
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < mpcb_pkg::AXES; i++)
                    t[i] = mpcb_pkg::POS_BITS'($urandom());
            end
            send_item(mpcb_pkg::OP_LOAD, t);
            n++;
            steps = $urandom_range(4, 16);
            for (int s = 0; s < steps; s++) begin
                for (int i = 0; i < mpcb_pkg::AXES; i++) begin
                    if ($urandom_range(0, 15) == 0)
                        p[i] = mpcb_pkg::POS_BITS'($urandom());
                    else if (s == steps - 1 && $urandom_range(0, 1))
                        p[i] = mpcb_pkg::POS_BITS'(longint'(t[i]) +
                               longint'($urandom_range(0, 4)) - 2);
                    else
                        p[i] = mpcb_pkg::POS_BITS'(longint'(p[i]) +
                               (longint'(t[i]) - longint'(p[i])) *
                               longint'($urandom_range(0, 8)) / 8 +
                               longint'($urandom_range(0, 20)) - 10);
                end
                send_item(mpcb_pkg::OP_SAMPLE, p);
                n++;
            end
        end
    endtask

    task automatic test_random();
        int lims [4] = '{1, 100, 4095, 0};
        for (int k = 0; k < 8; k++) begin
            if (k % 4 == 3) set_regs($urandom_range(1, 4095), $urandom_range(0, 1023),
                                      $urandom_range(0, 65535));
            else set_regs(lims[k%4] == 0 ? 1 : lims[k%4], $urandom_range(0, 8),
                          (k % 2) ? 65535 : $urandom_range(100, 2000));
            no_idle = (k == 2);
            run_episodes(100);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        pos_vec_t p;
        set_regs(100, 2, 256);
        @(posedge aclk);
        hold_left = 400;
        for (int n = 0; n < 20; n++) begin
            for (int i = 0; i < mpcb_pkg::AXES; i++) p[i] = mpcb_pkg::POS_BITS'($urandom());
            send_item(n % 5 == 0 ? mpcb_pkg::OP_LOAD : mpcb_pkg::OP_SAMPLE, p);
        end
    endtask

    initial begin
        lim_reg = mpcb_pkg::SPEED_LIMIT_RESET;
        acc_reg = mpcb_pkg::ACCURACY_LIMIT_RESET;
        scale_reg = mpcb_pkg::PWM_SCALE_RESET;
        for (int i = 0; i < mpcb_pkg::AXES; i++) begin
            tgt[i] = 0; prev_pos[i] = 0; ideal_spd[i] = 0; last_dir[i] = 0; last_duty[i] = 0;
        end
        for (int i = 0; i < mpcb_pkg::AXES*2; i++) dir_bias[i] = 0;
        pending = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        if (errors == 0 && expected_drives.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
sv/mpcb_pkg.sv
sv/mpcb_ctrl.sv
sv/mpcb_datapath.sv
sv/multi_axis_p_control_bias.sv
tb/tb_multi_axis_p_control_bias.sv
